/* design/stt_pkg.sv */
// Shared types, constants and command codes for the software timer table.
// No dependencies.
package stt_pkg;

  localparam int MAX_TIMERS_DEF = 32;
  localparam int TIME_W = 40;
  localparam int IVL_W = 24;
  localparam int SLOT_W = 5;
  localparam logic [15:0] FIXED_STEP_RST = 16'd15;
  localparam logic [15:0] THINK_PERIOD_RST = 16'd100;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ADD = 2'd1,
    CMD_KILL = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic {
    KIND_FIRE = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef enum logic {
    REG_FIXED_STEP = 1'b0,
    REG_THINK_PERIOD = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_ONE,
    S_SCAN_REP,
    S_DONE
  } state_t;

  // Control handed from the sequencer to every cell of the chain.
  typedef struct packed {
    logic add;       // write the add item into the cell whose grant is set
    logic kill;      // free the cell named by kill_slot
    logic remove;    // free map-change cells
    logic scan;      // compare the cell at the scan slot
    logic scan_rep;  // scan class: 1 repeating, 0 one-shot
  } cell_ctl_t;

endpackage

/* design/stt_if.sv */
// Valid/ready channel interfaces for the software timer table.
// Depends on stt_pkg.
interface stt_in_if;
  import stt_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [15:0] elapsed_ms;
  logic simulating;
  logic [23:0] interval_ms;
  logic repeat_flag;
  logic no_map_change;
  logic [4:0] timer_slot;
  modport source (output valid, cmd, elapsed_ms, simulating, interval_ms, repeat_flag,
                  no_map_change, timer_slot, input ready);
  modport sink (input valid, cmd, elapsed_ms, simulating, interval_ms, repeat_flag,
                no_map_change, timer_slot, output ready);
endinterface

interface stt_out_if;
  logic valid;
  logic ready;
  logic kind;
  logic [1:0] status;
  logic [4:0] slot;
  logic last;
  modport source (output valid, kind, status, slot, last, input ready);
  modport sink (input valid, kind, status, slot, last, output ready);
endinterface

interface stt_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/stt_cell.sv */
// One timer slot: valid, class, map-change flag, interval and expiry time.
// Depends on stt_pkg. Chained through the free-slot priority signal.
module stt_cell
  import stt_pkg::*;
#(
  parameter int IDX = 0,
  parameter int SW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [SW-1:0]     kill_slot,
  input  logic [SW-1:0]     scan_slot,
  input  logic [TIME_W-1:0] now,
  input  logic [IVL_W-1:0]  add_ivl,
  input  logic              add_rep,
  input  logic              add_map,
  input  logic              free_found_in,   // a lower slot is free
  output logic              free_found_out,
  output logic              valid,
  output logic              hit               // expired in the class being scanned
);

  logic              valid_r, valid_nxt;
  logic              rep_r, map_r;
  logic [IVL_W-1:0]  ivl_r;
  logic [TIME_W-1:0] exp_r;
  logic              grant, sel_scan, sel_kill;

  // Claim the add when no lower slot is free
  assign grant          = !valid_r && !free_found_in;
  assign free_found_out = free_found_in || !valid_r;
  assign sel_scan       = ctl.scan && (scan_slot == SW'(IDX));
  assign sel_kill       = ctl.kill && (kill_slot == SW'(IDX));
  assign hit = valid_r && (rep_r == ctl.scan_rep) && (now >= exp_r);
  assign valid = valid_r;

  // Next valid bit
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.add && grant) valid_nxt = 1'b1;
    if (sel_kill) valid_nxt = 1'b0;
    if (ctl.remove && map_r) valid_nxt = 1'b0;
    if (sel_scan && hit && !rep_r) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload: written by add, expiry rescheduled by a repeating fire
  always_ff @(posedge clk) begin
    if (ctl.add && grant) begin
      rep_r <= add_rep;
      map_r <= add_map;
      ivl_r <= add_ivl;
      exp_r <= now + TIME_W'(add_ivl);
    end else if (sel_scan && hit && rep_r) begin
      exp_r <= now + TIME_W'(ivl_r);
    end
  end

endmodule

/* design/software_timer_table.sv */
// Top level of the software timer table: sequencer, clock registers and the
// chain of timer cells. Depends on stt_pkg, stt_if and stt_cell.
//
// Usage: commands enter on the in_ channel (tick, add, kill, remove map-change
// timers); results leave on the out_ channel, one item per cycle when the
// receiver is ready. Every command ends with one done item (kind 1, last 1).
// Add, kill and remove pass from acceptance through the done state and the
// output register to the done item. A tick that reaches the think point
// scans the chain twice, one-shot timers then repeating timers, each from the
// highest slot down, one slot a cycle while the output register is free;
// a fire item is produced for each expired timer. A tick before the think
// point skips the scan. Only one command is in work at a time: in_ready is
// low until the done item has been taken. A stalled receiver holds the output
// register and freezes the scan. Configuration writes through cfg_ are taken
// at any cycle and must only come while the block is idle. Synchronous reset
// clears the clock, think time and all slot valid bits; registers return to
// fixed step 15 ms and think period 100 ms. No clearing pass is needed.
module software_timer_table
  import stt_pkg::*;
#(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  stt_in_if.sink     in_ch,
  stt_out_if.source  out_ch,
  stt_cfg_if.sink    cfg_ch
);

  localparam int SW = SLOT_W;

  state_t            state_r, state_nxt;
  logic [15:0]       fixed_step_r, think_period_r;
  logic [TIME_W-1:0] now_r, think_r;
  logic [SW-1:0]     idx_r, idx_nxt;
  logic              o_valid_r, o_kind_r, o_last_r;
  logic [1:0]        o_status_r;
  logic [SW-1:0]     o_slot_r;
  logic [1:0]        cmd_r;
  logic [IVL_W-1:0]  ivl_r;
  logic              rep_r, map_r;
  logic [SW-1:0]     kslot_r;
  logic [TIME_W-1:0] now_nxt;
  logic              accept, o_free, cur_hit, last_idx;
  cell_ctl_t         ctl;
  logic [MAX_TIMERS:0]   chain;
  logic [MAX_TIMERS-1:0] vld, hits;
  logic [SW-1:0]     add_slot;
  logic              kill_ok;

  assign accept = in_ch.valid && in_ch.ready;
  assign o_free = !o_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !o_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign cur_hit = hits[idx_r];
  assign last_idx = (idx_r == '0);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_step_r   <= FIXED_STEP_RST;
      think_period_r <= THINK_PERIOD_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_FIXED_STEP) fixed_step_r <= cfg_ch.data;
      else think_period_r <= cfg_ch.data;
    end
  end

  // Latch the command item
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_ch.cmd;
      ivl_r   <= in_ch.interval_ms;
      rep_r   <= in_ch.repeat_flag;
      map_r   <= in_ch.no_map_change;
      kslot_r <= in_ch.timer_slot;
    end
  end

  // Advance the clock on tick acceptance
  assign now_nxt = now_r + TIME_W'(in_ch.simulating ? in_ch.elapsed_ms : fixed_step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r   <= '0;
      think_r <= '0;
    end else begin
      if (accept && cmd_t'(in_ch.cmd) == CMD_TICK) now_r <= now_nxt;
      if (state_r == S_SCAN_REP && o_free && last_idx)
        think_r <= now_r + TIME_W'(think_period_r);
    end
  end

  // Next state and scan index
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DONE;
          if (cmd_t'(in_ch.cmd) == CMD_TICK && now_nxt >= think_r) begin
            state_nxt = S_SCAN_ONE;
            idx_nxt   = SW'(MAX_TIMERS - 1);
          end
        end
      end
      S_SCAN_ONE: begin
        if (o_free) begin
          idx_nxt = idx_r - 1'b1;
          if (last_idx) begin
            state_nxt = S_SCAN_REP;
            idx_nxt   = SW'(MAX_TIMERS - 1);
          end
        end
      end
      S_SCAN_REP: begin
        if (o_free) begin
          idx_nxt = idx_r - 1'b1;
          if (last_idx) state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (o_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Cell controls
  always_comb begin
    ctl = '0;
    ctl.scan_rep = (state_r == S_SCAN_REP);
    ctl.scan = o_free && (state_r == S_SCAN_ONE || state_r == S_SCAN_REP);
    if (state_r == S_DONE && o_free) begin
      ctl.add    = (cmd_t'(cmd_r) == CMD_ADD);
      ctl.kill   = (cmd_t'(cmd_r) == CMD_KILL);
      ctl.remove = (cmd_t'(cmd_r) == CMD_REMOVE);
    end
  end

  // Chain of timer cells
  assign chain[0] = 1'b0;
  for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
    stt_cell #(.IDX(g), .SW(SW)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .kill_slot(kslot_r), .scan_slot(idx_r), .now(now_r),
      .add_ivl(ivl_r), .add_rep(rep_r), .add_map(map_r),
      .free_found_in(chain[g]), .free_found_out(chain[g+1]),
      .valid(vld[g]), .hit(hits[g])
    );
  end

  // Lowest free slot for the add done item
  always_comb begin
    add_slot = '0;
    for (int k = MAX_TIMERS - 1; k >= 0; k--) begin
      if (!vld[k]) add_slot = SW'(k);
    end
  end

  assign kill_ok = (32'(kslot_r) < MAX_TIMERS) && vld[kslot_r];

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_free) begin
      o_valid_r <= 1'b0;
      if (ctl.scan && cur_hit) begin
        o_valid_r  <= 1'b1;
        o_kind_r   <= KIND_FIRE;
        o_status_r <= ST_OK;
        o_slot_r   <= idx_r;
        o_last_r   <= 1'b0;
      end else if (state_r == S_DONE) begin
        o_valid_r  <= 1'b1;
        o_kind_r   <= KIND_DONE;
        o_status_r <= ST_OK;
        o_slot_r   <= '0;
        o_last_r   <= 1'b1;
        if (cmd_t'(cmd_r) == CMD_ADD) begin
          if (chain[MAX_TIMERS]) o_slot_r <= add_slot;
          else o_status_r <= ST_FULL;
        end else if (cmd_t'(cmd_r) == CMD_KILL) begin
          if (kill_ok) o_slot_r <= kslot_r;
          else o_status_r <= ST_NOT_FOUND;
        end
      end
    end
  end

  assign out_ch.valid  = o_valid_r;
  assign out_ch.kind   = o_kind_r;
  assign out_ch.status = o_status_r;
  assign out_ch.slot   = o_slot_r;
  assign out_ch.last   = o_last_r;

endmodule

/* tb/tb_software_timer_table.sv */
// Self-checking testbench for the software timer table: directed table, then
// random command streams checked against a behavioral timer-table predictor.
// Depends on stt_pkg, stt_if and software_timer_table.
`timescale 1ns / 100ps

module tb_software_timer_table;
  import stt_pkg::*;

  localparam int NT = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] elapsed_ms;
    logic        simulating;
    logic [23:0] interval_ms;
    logic        repeat_flag;
    logic        no_map_change;
    logic [4:0]  timer_slot;
  } cmd_item_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [4:0]  slot;
    logic        last;
  } result_t;

  // Directed row: command plus an optional typed expectation for the done item.
  typedef struct packed {
    cmd_item_t   item;
    logic        has_exp;
    status_t     exp_status;
    logic [4:0]  exp_slot;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  int   idle_cycles = 0;

  stt_in_if  in_ch();
  stt_out_if out_ch();
  stt_cfg_if cfg_ch();

  software_timer_table u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Predictor copy of the table
  logic [15:0] step_cfg;
  logic [15:0] period_cfg;
  logic [39:0] now_ms;
  logic [39:0] think_at;
  logic        live [NT];
  logic        rep [NT];
  logic        mapc [NT];
  logic [39:0] due [NT];
  logic [23:0] ivl [NT];
  result_t     pending_results[$];
  row_t        overrides[$];

  function automatic result_t mk(kind_t k, status_t s, logic [4:0] sl, logic l);
    result_t r;
    r.kind = k; r.status = s; r.slot = sl; r.last = l;
    return r;
  endfunction

  // Append one expected result item
  function automatic void queue_result(result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  task automatic predict_timer_cmd(input cmd_item_t it);
    logic [39:0] adv;
    int i;
    bit found;
    found = 0;
    case (it.cmd)
      CMD_TICK: begin
        adv = it.simulating ? {24'd0, it.elapsed_ms} : {24'd0, step_cfg};
        now_ms = now_ms + adv;
        if (now_ms >= think_at) begin
          for (i = NT - 1; i >= 0; i--)
            if (live[i] && !rep[i] && now_ms >= due[i]) begin
              queue_result(mk(KIND_FIRE, ST_OK, i[4:0], 1'b0));
              live[i] = 1'b0;
            end
          for (i = NT - 1; i >= 0; i--)
            if (live[i] && rep[i] && now_ms >= due[i]) begin
              queue_result(mk(KIND_FIRE, ST_OK, i[4:0], 1'b0));
              due[i] = now_ms + {16'd0, ivl[i]};
            end
          think_at = now_ms + {24'd0, period_cfg};
        end
        queue_result(mk(KIND_DONE, ST_OK, 5'd0, 1'b1));
      end
      CMD_ADD: begin
        for (i = 0; i < NT && !found; i++)
          if (!live[i]) begin
            found = 1;
            live[i] = 1'b1; rep[i] = it.repeat_flag; mapc[i] = it.no_map_change;
            ivl[i] = it.interval_ms; due[i] = now_ms + {16'd0, it.interval_ms};
            queue_result(mk(KIND_DONE, ST_OK, i[4:0], 1'b1));
          end
        if (!found) queue_result(mk(KIND_DONE, ST_FULL, 5'd0, 1'b1));
      end
      CMD_KILL: begin
        if (live[it.timer_slot]) begin
          live[it.timer_slot] = 1'b0;
          queue_result(mk(KIND_DONE, ST_OK, it.timer_slot, 1'b1));
        end else begin
          queue_result(mk(KIND_DONE, ST_NOT_FOUND, 5'd0, 1'b1));
        end
      end
      default: begin
        for (i = 0; i < NT; i++)
          if (live[i] && mapc[i]) live[i] = 1'b0;
        queue_result(mk(KIND_DONE, ST_OK, 5'd0, 1'b1));
      end
    endcase
  endtask

  // Result checker and receiver stall pattern
  logic [7:0] stall_lfsr = 8'h5a;
  always @(posedge clk) begin
    result_t got, want;
    row_t ov;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4]
                     ^ stall_lfsr[3]};
      out_ch.ready <= (stall_lfsr[2:0] != 3'b000) || stall_lfsr[7];
      if (out_ch.valid && out_ch.ready) begin
        got = mk(kind_t'(out_ch.kind), status_t'(out_ch.status), out_ch.slot, out_ch.last);
        if (pending_results.size() == 0) begin
          $error("unexpected result item kind=%0d slot=%0d", got.kind, got.slot);
          errors++;
        end else begin
          want = pending_results.pop_front();
          // Typed-in row expectations apply to done items of directed rows
          if (want.kind == KIND_DONE && overrides.size() > 0) begin
            ov = overrides.pop_front();
            if (ov.has_exp && (ov.exp_status != want.status || ov.exp_slot != want.slot)) begin
              $error("table row status/slot exp %0d/%0d, predictor %0d/%0d",
                     ov.exp_status, ov.exp_slot, want.status, want.slot);
              errors++;
            end
          end
          if (got.kind !== want.kind) begin
            $error("kind exp %0d got %0d", want.kind, got.kind); errors++;
          end
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); errors++;
          end
          if (got.slot !== want.slot) begin
            $error("slot exp %0d got %0d", want.slot, got.slot); errors++;
          end
          if (got.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, got.last); errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_software_timer_table: errors");
      $finish;
    end
  end

  int burst_left = 0;

  // Send one item, with bursty gaps; valid stays high across a burst
  task automatic send_cmd(input cmd_item_t it, input bit gaps);
    int gap;
    if (gaps && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= it.cmd;
    in_ch.elapsed_ms <= it.elapsed_ms;
    in_ch.simulating <= it.simulating;
    in_ch.interval_ms <= it.interval_ms;
    in_ch.repeat_flag <= it.repeat_flag;
    in_ch.no_map_change <= it.no_map_change;
    in_ch.timer_slot <= it.timer_slot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_timer_cmd(it);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_FIXED_STEP) step_cfg = val; else period_cfg = val;
  endtask

  function automatic cmd_item_t rand_cmd(input bit well_formed);
    cmd_item_t it;
    logic [63:0] raw;
    int pick;
    raw = {$urandom, $urandom};
    it = raw[$bits(cmd_item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (well_formed) begin
      it.cmd = pick < 45 ? CMD_TICK : pick < 75 ? CMD_ADD : pick < 93 ? CMD_KILL : CMD_REMOVE;
      if ($urandom_range(0, 3) != 0) it.interval_ms = 24'($urandom_range(0, 600));
      if ($urandom_range(0, 2) != 0) it.elapsed_ms = 16'($urandom_range(0, 200));
    end
    return it;
  endfunction

  function automatic row_t row(cmd_t c, int el, int sim, int iv,
                               int rp, int mc, int ts, int he,
                               status_t es, int esl);
    row_t r;
    r.item.cmd = c; r.item.elapsed_ms = 16'(el); r.item.simulating = 1'(sim);
    r.item.interval_ms = 24'(iv); r.item.repeat_flag = 1'(rp);
    r.item.no_map_change = 1'(mc);
    r.item.timer_slot = 5'(ts); r.has_exp = 1'(he); r.exp_status = es;
    r.exp_slot = 5'(esl);
    return r;
  endfunction

  row_t directed[$];

  // Append one directed row
  function automatic void add_row(row_t r);
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    cmd_item_t it;
    int i;
    in_ch.valid = 1'b0; in_ch.cmd = CMD_TICK; in_ch.elapsed_ms = '0;
    in_ch.simulating = 1'b0; in_ch.interval_ms = '0; in_ch.repeat_flag = 1'b0;
    in_ch.no_map_change = 1'b0; in_ch.timer_slot = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_FIXED_STEP; cfg_ch.data = '0;
    step_cfg = FIXED_STEP_RST; period_cfg = THINK_PERIOD_RST;
    now_ms = '0; think_at = '0;
    for (i = 0; i < NT; i++) live[i] = 1'b0;

    // Directed table: reset values, extremes, special cases
    add_row(row(CMD_KILL, 0, 0, 0, 0, 0, 5'd0, 1, ST_NOT_FOUND, 0));
    add_row(row(CMD_KILL, 0, 0, 0, 0, 0, 5'd31, 1, ST_NOT_FOUND, 0));
    add_row(row(CMD_ADD, 0, 0, 24'd0, 0, 1, 0, 1, ST_OK, 5'd0));
    add_row(row(CMD_ADD, 0, 0, 24'd0, 1, 0, 0, 1, ST_OK, 5'd1));
    add_row(row(CMD_ADD, 0, 0, 24'hFFFFFF, 1, 1, 0, 1, ST_OK, 5'd2));
    add_row(row(CMD_ADD, 0, 0, 24'd40, 0, 0, 0, 1, ST_OK, 5'd3));
    add_row(row(CMD_TICK, 16'd0, 1, 0, 0, 0, 0, 0, ST_OK, 0));
    add_row(row(CMD_TICK, 16'd5, 1, 0, 0, 0, 0, 1, ST_OK, 0));
    add_row(row(CMD_TICK, 16'hFFFF, 1, 0, 0, 0, 0, 0, ST_OK, 0));
    add_row(row(CMD_TICK, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0));
    add_row(row(CMD_KILL, 0, 0, 0, 0, 0, 5'd1, 1, ST_OK, 5'd1));
    add_row(row(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0));
    add_row(row(CMD_KILL, 0, 0, 0, 0, 0, 5'd2, 1, ST_NOT_FOUND, 0));
    for (i = 0; i < 32; i++) add_row(row(CMD_ADD, 0, 0, 24'd3, i[0], i[1],
                                         0, 0, ST_OK, 0));
    add_row(row(CMD_ADD, 0, 0, 24'd1, 0, 0, 0, 1, ST_FULL, 0));
    add_row(row(CMD_TICK, 16'd200, 1, 0, 0, 0, 0, 1, ST_OK, 0));
    add_row(row(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      overrides.insert(overrides.size(), directed[k]);
      send_cmd(directed[k].item, 0);
    end
    drain_results();

    // Random phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_FIXED_STEP, 16'd0); write_reg(REG_THINK_PERIOD, 16'd0); end
        1: begin write_reg(REG_FIXED_STEP, 16'hFFFF); write_reg(REG_THINK_PERIOD, 16'hFFFF); end
        2: begin write_reg(REG_FIXED_STEP, 16'd15); write_reg(REG_THINK_PERIOD, 16'd100); end
        default: begin
          write_reg(REG_FIXED_STEP, 16'($urandom_range(0, 300)));
          write_reg(REG_THINK_PERIOD, 16'($urandom_range(0, 150)));
        end
      endcase
      for (i = 0; i < 50; i++) begin
        it = rand_cmd($urandom_range(0, 9) != 0);
        send_cmd(it, (ph % 3) != 1);
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("tb_software_timer_table: clean");
    end else begin
      $display("tb_software_timer_table: errors");
    end
    $finish;
  end

endmodule
